// ===== design/adq_pkg.sv =====
// Shared types, constants and the register-write table of the ATA DMA issue queue.
`default_nettype none

package adq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH  = 8;
  localparam int NUM_CHANNELS = 2;
  localparam int PtrW         = $clog2(QUEUE_DEPTH);
  localparam int CntW         = $clog2(QUEUE_DEPTH + 1);
  localparam int StoreDepth   = NUM_CHANNELS * QUEUE_DEPTH;
  localparam int StoreAw      = $clog2(StoreDepth);

  // Configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] CFG_DMA_CHAN  = 2'd1;
  localparam logic [1:0] CFG_PRDT_PRI  = 2'd2;
  localparam logic [1:0] CFG_PRDT_SEC  = 2'd3;

  // Drive addressing modes
  localparam logic [1:0] MODE_CHS   = 2'd0;
  localparam logic [1:0] MODE_LBA28 = 2'd1;
  localparam logic [1:0] MODE_LBA48 = 2'd2;

  // Register offsets
  localparam logic [2:0] BM_OFF_CMD    = 3'd0;
  localparam logic [2:0] BM_OFF_STATUS = 3'd2;
  localparam logic [2:0] BM_OFF_PRDT   = 3'd4;
  localparam logic [2:0] TF_OFF_COUNT  = 3'd2;
  localparam logic [2:0] TF_OFF_LBA_LO = 3'd3;
  localparam logic [2:0] TF_OFF_LBA_MD = 3'd4;
  localparam logic [2:0] TF_OFF_LBA_HI = 3'd5;
  localparam logic [2:0] TF_OFF_DEVSEL = 3'd6;
  localparam logic [2:0] TF_OFF_CMD    = 3'd7;

  // Register values
  localparam logic [7:0] DEVSEL_BASE   = 8'hE0;
  localparam logic [7:0] DEVSEL_SLAVE  = 8'h10;
  localparam logic [7:0] DEVSEL_HEAD   = 8'h0F;
  localparam logic [7:0] ATA_RD_EXT    = 8'h25;
  localparam logic [7:0] ATA_WR_EXT    = 8'h35;
  localparam logic [7:0] ATA_RD_DMA    = 8'hC8;
  localparam logic [7:0] ATA_WR_DMA    = 8'hCA;
  localparam logic [7:0] BM_START_RD   = 8'h09;
  localparam logic [7:0] BM_START_WR   = 8'h01;
  localparam logic [7:0] BM_STOP       = 8'h00;
  localparam logic [7:0] BM_STAT_CLR   = 8'h03;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;

  // Last step of each issue program
  localparam logic [3:0] LAST_STEP_48 = 4'd12;
  localparam logic [3:0] LAST_STEP_28 = 4'd9;

  typedef enum logic [1:0] {
    KIND_TASKFILE  = 2'd0,
    KIND_BUSMASTER = 2'd1,
    KIND_DONE      = 2'd2,
    KIND_REJECT    = 2'd3
  } kind_e;

  // One queued request
  typedef struct packed {
    logic [47:0] lba;
    logic [15:0] count;
    logic        slave;
    logic        is_write;
    logic [7:0]  tag;
  } req_t;

  // One register write of an issue program
  typedef struct packed {
    kind_e       kind;
    logic [2:0]  off;
    logic [31:0] value;
    logic        last;
  } wr_t;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic        ch;
    logic [2:0]  off;
    logic [31:0] value;
    logic        ok;
    logic [7:0]  tag;
    logic        last;
  } res_t;

  // Byte shifter shared by every taskfile address write
  function automatic logic [7:0] lba_byte(input logic [47:0] lba, input logic [2:0] sel);
    logic [47:0] sh;
    sh = lba >> {sel, 3'b000};
    return sh[7:0];
  endfunction

  // Register write for one step of the issue program
  function automatic wr_t issue_write(input logic [3:0] step, input logic mode48,
                                      input req_t req, input logic [31:0] prdt);
    wr_t        w;
    logic [7:0] devsel;
    logic [7:0] cmd;
    logic [7:0] b;
    devsel = DEVSEL_BASE | (req.slave ? DEVSEL_SLAVE : ZERO_BYTE) |
             ({4'b0000, req.lba[27:24]} & DEVSEL_HEAD);
    if (mode48) begin
      cmd = req.is_write ? ATA_WR_EXT : ATA_RD_EXT;
    end else begin
      cmd = req.is_write ? ATA_WR_DMA : ATA_RD_DMA;
    end
    w.kind  = KIND_TASKFILE;
    w.off   = TF_OFF_CMD;
    w.value = '0;
    w.last  = 1'b0;
    b       = ZERO_BYTE;
    if (step == 4'd0) begin
      w.kind  = KIND_BUSMASTER;
      w.off   = BM_OFF_PRDT;
      w.value = prdt;
    end else if (step == 4'd1) begin
      w.kind  = KIND_BUSMASTER;
      w.off   = BM_OFF_STATUS;
      b       = BM_STAT_CLR;
    end else if (mode48) begin
      unique case (step)
        4'd2:    begin w.off = TF_OFF_DEVSEL; b = devsel; end
        4'd3:    begin w.off = TF_OFF_COUNT;  b = req.count[15:8]; end
        4'd4:    begin w.off = TF_OFF_LBA_LO; b = lba_byte(req.lba, 3'd3); end
        4'd5:    begin w.off = TF_OFF_LBA_MD; b = lba_byte(req.lba, 3'd4); end
        4'd6:    begin w.off = TF_OFF_LBA_HI; b = lba_byte(req.lba, 3'd5); end
        4'd7:    begin w.off = TF_OFF_COUNT;  b = req.count[7:0]; end
        4'd8:    begin w.off = TF_OFF_LBA_LO; b = lba_byte(req.lba, 3'd0); end
        4'd9:    begin w.off = TF_OFF_LBA_MD; b = lba_byte(req.lba, 3'd1); end
        4'd10:   begin w.off = TF_OFF_LBA_HI; b = lba_byte(req.lba, 3'd2); end
        4'd11:   begin w.off = TF_OFF_CMD;    b = cmd; end
        default: begin
          w.kind = KIND_BUSMASTER;
          w.off  = BM_OFF_CMD;
          b      = req.is_write ? BM_START_WR : BM_START_RD;
        end
      endcase
    end else begin
      unique case (step)
        4'd2:    begin w.off = TF_OFF_COUNT;  b = ZERO_BYTE; end
        4'd3:    begin w.off = TF_OFF_DEVSEL; b = devsel; end
        4'd4:    begin w.off = TF_OFF_COUNT;  b = req.count[7:0]; end
        4'd5:    begin w.off = TF_OFF_LBA_LO; b = lba_byte(req.lba, 3'd0); end
        4'd6:    begin w.off = TF_OFF_LBA_MD; b = lba_byte(req.lba, 3'd1); end
        4'd7:    begin w.off = TF_OFF_LBA_HI; b = lba_byte(req.lba, 3'd2); end
        4'd8:    begin w.off = TF_OFF_CMD;    b = cmd; end
        default: begin
          w.kind = KIND_BUSMASTER;
          w.off  = BM_OFF_CMD;
          b      = req.is_write ? BM_START_WR : BM_START_RD;
        end
      endcase
    end
    if (step != 4'd0) begin
      w.value = {24'b0, b};
    end
    w.last = (step == (mode48 ? LAST_STEP_48 : LAST_STEP_28));
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/adq_req_store.sv =====
// Request store: one-write, one-read memory with registered read data.
`default_nettype none

module adq_req_store (
  input  wire                     clk_i,
  input  wire                     wr_en_i,
  input  wire [adq_pkg::StoreAw-1:0] wr_addr_i,
  input  wire adq_pkg::req_t      wr_data_i,
  input  wire                     rd_en_i,
  input  wire [adq_pkg::StoreAw-1:0] rd_addr_i,
  output adq_pkg::req_t           rd_data_o
);
  import adq_pkg::*;

  req_t mem [StoreDepth];
  req_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== design/ata_dma_command_issue_queue_top.sv =====
// Top level: per-channel request queues and the register-write sequencer.
// An item is taken only in idle; its results then leave from the output register,
// one per cycle while the output is not stalled, bar the store fetch; a reject gives a single result.
// Issue runs are 10 (LBA28) or 13 (LBA48) results; an interrupt gives 2, 3 or up to 16
// results, and a store fetch comes before a follow-on issue run.
// The store has one read port; the single sequencer and output register set the rate.
// Reset clears state, settings, pointers and counts; payload registers and the store are not.
`default_nettype none

module ata_dma_command_issue_queue_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         command_i,
  input  wire         channel_i,
  input  wire         slave_i,
  input  wire  [47:0] lba_i,
  input  wire  [15:0] xfer_len_i,
  input  wire         is_write_i,
  input  wire  [7:0]  tag_i,
  input  wire         bm_error_i,
  input  wire         drive_error_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  kind_o,
  output logic        port_channel_o,
  output logic [2:0]  reg_offset_o,
  output logic [31:0] write_value_o,
  output logic        done_ok_o,
  output logic [7:0]  done_tag_o,
  output logic        last_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i
);
  import adq_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_REJ   = 3'd1;
  localparam logic [2:0] S_STOP  = 3'd2;
  localparam logic [2:0] S_CLR   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_FETCH = 3'd5;
  localparam logic [2:0] S_ISSUE = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic        ch_q, ch_d;
  logic        ok_q, ok_d;
  logic [7:0]  tag_q, tag_d;
  req_t        req_q, req_d;

  logic [PtrW-1:0] head_q [2];
  logic [PtrW-1:0] head_d [2];
  logic [PtrW-1:0] tail_q [2];
  logic [PtrW-1:0] tail_d [2];
  logic [CntW-1:0] count_q [2];
  logic [CntW-1:0] count_d [2];

  logic [7:0]  dev_addr_q;
  logic [1:0]  dma_chan_q;
  logic [31:0] prdt_pri_q;
  logic [31:0] prdt_sec_q;

  logic        out_valid_q, out_valid_d;
  res_t        out_res_q, out_res_d;
  logic        out_load;

  logic              st_wr_en;
  logic [StoreAw-1:0] st_wr_addr;
  logic              st_rd_en;
  logic [StoreAw-1:0] st_rd_addr;
  req_t              st_rd_data;
  req_t              in_req;

  logic [1:0]  in_mode;
  logic        in_ch_ok;
  logic        in_reject;
  logic        iss_mode48;
  logic [31:0] iss_prdt;
  wr_t         iss_wr;
  logic [PtrW-1:0] head_next;

  // Addressing mode of one drive
  function automatic logic [1:0] drive_mode(input logic [7:0] da, input logic ch,
                                            input logic slave);
    logic [7:0] sh;
    sh = da >> {ch, slave, 1'b0};
    return sh[1:0];
  endfunction

  // Store address of a queue slot
  function automatic logic [StoreAw-1:0] slot_addr(input logic ch, input logic [PtrW-1:0] p);
    return ch ? (StoreAw'(QUEUE_DEPTH) + StoreAw'(p)) : StoreAw'(p);
  endfunction

  // Advance a ring pointer
  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  adq_req_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (st_wr_addr),
    .wr_data_i (in_req),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data)
  );

  // Configuration writes, always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
      dma_chan_q <= '0;
      prdt_pri_q <= '0;
      prdt_sec_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEV_ADDR: dev_addr_q <= cfg_data_i[7:0];
        CFG_DMA_CHAN: dma_chan_q <= cfg_data_i[1:0];
        CFG_PRDT_PRI: prdt_pri_q <= cfg_data_i;
        CFG_PRDT_SEC: prdt_sec_q <= cfg_data_i;
        default:      dev_addr_q <= dev_addr_q;
      endcase
    end
  end

  // Submit checks on the incoming request
  assign in_req    = '{lba: lba_i, count: xfer_len_i, slave: slave_i,
                       is_write: is_write_i, tag: tag_i};
  assign in_mode   = drive_mode(dev_addr_q, channel_i, slave_i);
  assign in_ch_ok  = (NUM_CHANNELS > 1) || !channel_i;
  assign in_reject = !in_ch_ok || !dma_chan_q[channel_i] ||
                     !((in_mode == MODE_LBA28) || (in_mode == MODE_LBA48)) ||
                     (count_q[channel_i] >= CntW'(QUEUE_DEPTH));

  // Issue program step, against the current registers
  assign iss_mode48 = (drive_mode(dev_addr_q, ch_q, req_q.slave) == MODE_LBA48);
  assign iss_prdt   = ch_q ? prdt_sec_q : prdt_pri_q;
  assign iss_wr     = issue_write(step_q, iss_mode48, req_q, iss_prdt);
  assign head_next  = ring_next(head_q[ch_q]);

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign st_wr_addr = slot_addr(channel_i, tail_q[channel_i]);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ch_d        = ch_q;
    ok_d        = ok_q;
    tag_d       = tag_q;
    req_d       = req_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    st_wr_en    = 1'b0;
    st_rd_en    = 1'b0;
    st_rd_addr  = slot_addr(ch_q, head_q[ch_q]);
    if (out_load) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ch_d  = channel_i;
          tag_d = tag_i;
          ok_d  = !(bm_error_i || drive_error_i);
          if (!command_i) begin
            if (in_reject) begin
              state_d = S_REJ;
            end else begin
              // queue the request, issue it at once if the queue was empty
              st_wr_en           = 1'b1;
              tail_d[channel_i]  = ring_next(tail_q[channel_i]);
              count_d[channel_i] = count_q[channel_i] + CntW'(1);
              if (count_q[channel_i] == '0) begin
                req_d   = in_req;
                step_d  = '0;
                state_d = S_ISSUE;
              end
            end
          end else if (in_ch_ok) begin
            state_d = S_STOP;
          end
        end
      end
      S_REJ: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_res_d   = '{kind: KIND_REJECT, ch: ch_q, off: '0, value: '0,
                          ok: 1'b0, tag: tag_q, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_STOP: begin
        if (out_load) begin
          // stop the bus master, fetch the request in flight
          out_valid_d = 1'b1;
          out_res_d   = '{kind: KIND_BUSMASTER, ch: ch_q, off: BM_OFF_CMD,
                          value: {24'b0, BM_STOP}, ok: 1'b0, tag: '0, last: 1'b0};
          st_rd_en    = 1'b1;
          state_d     = S_CLR;
        end
      end
      S_CLR: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_res_d   = '{kind: KIND_BUSMASTER, ch: ch_q, off: BM_OFF_STATUS,
                          value: {24'b0, BM_STAT_CLR}, ok: 1'b0, tag: '0,
                          last: (count_q[ch_q] == '0)};
          state_d     = (count_q[ch_q] == '0) ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          // complete the head request, fetch the next one if any
          out_valid_d   = 1'b1;
          out_res_d     = '{kind: KIND_DONE, ch: ch_q, off: '0, value: '0, ok: ok_q,
                            tag: st_rd_data.tag, last: (count_q[ch_q] == CntW'(1))};
          head_d[ch_q]  = head_next;
          count_d[ch_q] = count_q[ch_q] - CntW'(1);
          if (count_q[ch_q] == CntW'(1)) begin
            state_d = S_IDLE;
          end else begin
            st_rd_en   = 1'b1;
            st_rd_addr = slot_addr(ch_q, head_next);
            state_d    = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        req_d   = st_rd_data;
        step_d  = '0;
        state_d = S_ISSUE;
      end
      S_ISSUE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_res_d   = '{kind: iss_wr.kind, ch: ch_q, off: iss_wr.off,
                          value: iss_wr.value, ok: 1'b0, tag: '0, last: iss_wr.last};
          if (iss_wr.last) begin
            state_d = S_IDLE;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        head_q[c]  <= '0;
        tail_q[c]  <= '0;
        count_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    ok_q      <= ok_d;
    tag_q     <= tag_d;
    req_q     <= req_d;
    out_res_q <= out_res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_res_q.kind;
  assign port_channel_o = out_res_q.ch;
  assign reg_offset_o   = out_res_q.off;
  assign write_value_o  = out_res_q.value;
  assign done_ok_o      = out_res_q.ok;
  assign done_tag_o     = out_res_q.tag;
  assign last_o         = out_res_q.last;

  // Queue occupancy never passes the depth
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q[0] <= CntW'(QUEUE_DEPTH)) && (count_q[1] <= CntW'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  // An empty primary queue has its pointers together
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q[0] == '0) |-> (head_q[0] == tail_q[0]))
    else $error("empty queue with split pointers");

  // Completion only with a request in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) || (state_q == S_FETCH)) |-> (count_q[ch_q] != '0))
    else $error("completion on empty queue");

  // Issue program stays within its steps
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> (step_q <= LAST_STEP_48))
    else $error("issue step out of range");

  // A fetch always leads into an issue run
  a_fetch_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> (state_q == S_ISSUE) && (step_q == '0))
    else $error("fetch not followed by issue");

endmodule

`default_nettype wire

// ===== tb/ata_dma_command_issue_queue_top_tb.sv =====
// Testbench for the ATA DMA issue queue: random and directed requests against a scoreboard.
`timescale 1ns / 1ps

import adq_pkg::*;

// Request codes and the addressing mode the package leaves unnamed
localparam logic       CMD_SUBMIT     = 1'b0;
localparam logic       CMD_IRQ        = 1'b1;
localparam logic [1:0] MODE_RESERVED  = 2'd3;

// One request as offered on the input side
typedef struct packed {
  logic        command;
  logic        channel;
  logic        slave;
  logic [47:0] lba;
  logic [15:0] count;
  logic        is_write;
  logic [7:0]  tag;
  logic        bm_error;
  logic        drive_error;
} adq_request_t;

// Queue and register model with the list of register writes still owed
class adq_scoreboard;
  res_t        owed_q[$];
  res_t        run_q[$];
  logic [7:0]  dev_addr;
  logic [1:0]  dma_mask;
  logic [31:0] prdt_addr[2];
  req_t        slots[2][QUEUE_DEPTH];
  int unsigned head[2];
  int unsigned tail[2];
  int unsigned fill[2];
  int unsigned errors;
  int unsigned shown;

  function new();
    dev_addr = '0;
    dma_mask = '0;
    errors   = 0;
    shown    = 0;
    for (int c = 0; c < 2; c++) begin
      prdt_addr[c] = '0;
      head[c]      = 0;
      tail[c]      = 0;
      fill[c]      = 0;
    end
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      CFG_DEV_ADDR: dev_addr     = data[7:0];
      CFG_DMA_CHAN: dma_mask     = data[1:0];
      CFG_PRDT_PRI: prdt_addr[0] = data;
      CFG_PRDT_SEC: prdt_addr[1] = data;
      default: ;
    endcase
  endfunction

  function logic [1:0] drive_mode(logic ch, logic slave);
    return dev_addr[{ch, slave} * 2 +: 2];
  endfunction

  function void push(kind_e k, logic ch, logic [2:0] off, logic [31:0] val,
                     logic ok = 1'b0, logic [7:0] tag = 8'h00);
    res_t r;
    r.kind  = k;
    r.ch    = ch;
    r.off   = off;
    r.value = val;
    r.ok    = ok;
    r.tag   = tag;
    r.last  = 1'b0;
    run_q.push_back(r);
  endfunction

  // Byte-wide register write
  function void push_byte(kind_e k, logic ch, logic [2:0] off, logic [7:0] b);
    push(k, ch, off, {24'h00_0000, b});
  endfunction

  // Register program that starts one transfer
  function void issue_run(logic ch, req_t q);
    logic [7:0] devsel;
    logic [7:0] cmd;
    logic       mode48;
    devsel = DEVSEL_BASE | (q.slave ? DEVSEL_SLAVE : ZERO_BYTE) | {4'h0, q.lba[27:24]};
    mode48 = (drive_mode(ch, q.slave) == MODE_LBA48);
    push(KIND_BUSMASTER, ch, BM_OFF_PRDT, prdt_addr[ch]);
    push_byte(KIND_BUSMASTER, ch, BM_OFF_STATUS, BM_STAT_CLR);
    if (mode48) begin
      push_byte(KIND_TASKFILE, ch, TF_OFF_DEVSEL, devsel);
      push_byte(KIND_TASKFILE, ch, TF_OFF_COUNT, q.count[15:8]);
      push_byte(KIND_TASKFILE, ch, TF_OFF_LBA_LO, q.lba[31:24]);
      push_byte(KIND_TASKFILE, ch, TF_OFF_LBA_MD, q.lba[39:32]);
      push_byte(KIND_TASKFILE, ch, TF_OFF_LBA_HI, q.lba[47:40]);
      push_byte(KIND_TASKFILE, ch, TF_OFF_COUNT, q.count[7:0]);
      push_byte(KIND_TASKFILE, ch, TF_OFF_LBA_LO, q.lba[7:0]);
      push_byte(KIND_TASKFILE, ch, TF_OFF_LBA_MD, q.lba[15:8]);
      push_byte(KIND_TASKFILE, ch, TF_OFF_LBA_HI, q.lba[23:16]);
      cmd = q.is_write ? ATA_WR_EXT : ATA_RD_EXT;
    end else begin
      push_byte(KIND_TASKFILE, ch, TF_OFF_COUNT, ZERO_BYTE);
      push_byte(KIND_TASKFILE, ch, TF_OFF_DEVSEL, devsel);
      push_byte(KIND_TASKFILE, ch, TF_OFF_COUNT, q.count[7:0]);
      push_byte(KIND_TASKFILE, ch, TF_OFF_LBA_LO, q.lba[7:0]);
      push_byte(KIND_TASKFILE, ch, TF_OFF_LBA_MD, q.lba[15:8]);
      push_byte(KIND_TASKFILE, ch, TF_OFF_LBA_HI, q.lba[23:16]);
      cmd = q.is_write ? ATA_WR_DMA : ATA_RD_DMA;
    end
    push_byte(KIND_TASKFILE, ch, TF_OFF_CMD, cmd);
    push_byte(KIND_BUSMASTER, ch, BM_OFF_CMD, q.is_write ? BM_START_WR : BM_START_RD);
  endfunction

  // Work out the writes and completions caused by one accepted request
  function void note_request(adq_request_t r);
    req_t       q;
    res_t       tip;
    logic [1:0] mode;
    logic       ch;
    run_q.delete();
    ch = r.channel;
    if (r.command == CMD_SUBMIT) begin
      q.lba      = r.lba;
      q.count    = r.count;
      q.slave    = r.slave;
      q.is_write = r.is_write;
      q.tag      = r.tag;
      mode       = drive_mode(ch, r.slave);
      if (!dma_mask[ch] || (mode != MODE_LBA28 && mode != MODE_LBA48) ||
          fill[ch] == QUEUE_DEPTH) begin
        push(KIND_REJECT, ch, 3'd0, 32'd0, 1'b0, r.tag);
      end else begin
        slots[ch][tail[ch]] = q;
        tail[ch] = (tail[ch] + 1) % QUEUE_DEPTH;
        fill[ch]++;
        if (fill[ch] == 1) issue_run(ch, q);
      end
    end else begin
      push_byte(KIND_BUSMASTER, ch, BM_OFF_CMD, BM_STOP);
      push_byte(KIND_BUSMASTER, ch, BM_OFF_STATUS, BM_STAT_CLR);
      if (fill[ch] != 0) begin
        push(KIND_DONE, ch, 3'd0, 32'd0, !(r.bm_error | r.drive_error),
             slots[ch][head[ch]].tag);
        head[ch] = (head[ch] + 1) % QUEUE_DEPTH;
        fill[ch]--;
        if (fill[ch] != 0) issue_run(ch, slots[ch][head[ch]]);
      end
    end
    // Mark the tail of the run and hand it over
    if (run_q.size() > 0) begin
      tip = run_q[run_q.size() - 1];
      tip.last = 1'b1;
      run_q[run_q.size() - 1] = tip;
    end
    foreach (run_q[i]) owed_q.push_back(run_q[i]);
  endfunction

  function void flag(string what, res_t want, res_t got);
    errors++;
    if (shown < 10) begin
      shown++;
      $display("%0t %s: want kind %0d ch %0d off %0d val %h ok %0d tag %h last %0d",
               $time, what, want.kind, want.ch, want.off, want.value, want.ok,
               want.tag, want.last);
      $display("      got  kind %0d ch %0d off %0d val %h ok %0d tag %h last %0d",
               got.kind, got.ch, got.off, got.value, got.ok, got.tag, got.last);
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (owed_q.size() == 0) begin
      flag("unexpected result", got, got);
    end else begin
      want = owed_q.pop_front();
      if (got.kind !== want.kind || got.ch !== want.ch || got.off !== want.off ||
          got.value !== want.value || got.ok !== want.ok || got.tag !== want.tag ||
          got.last !== want.last) begin
        flag("mismatch", want, got);
      end
    end
  endfunction

  function int pending();
    return owed_q.size();
  endfunction
endclass

module ata_dma_command_issue_queue_top_tb;

  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int RUN_LIMIT_NS  = 4_000_000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 45;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid       = 1'b0;
  logic        command        = 1'b0;
  logic        channel        = 1'b0;
  logic        slave          = 1'b0;
  logic [47:0] lba            = '0;
  logic [15:0] xfer_len       = '0;
  logic        is_write       = 1'b0;
  logic [7:0]  tag            = '0;
  logic        bm_error       = 1'b0;
  logic        drive_error    = 1'b0;
  logic        out_stall      = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic [1:0]  cfg_index      = '0;
  logic [31:0] cfg_data       = '0;
  logic        hold_trigger   = 1'b0;

  wire         in_stall_o;
  wire         out_valid_o;
  wire  [1:0]  kind_o;
  wire         port_channel_o;
  wire  [2:0]  reg_offset_o;
  wire  [31:0] write_value_o;
  wire         done_ok_o;
  wire  [7:0]  done_tag_o;
  wire         last_o;
  wire         cfg_ready_o;

  adq_scoreboard sb = new();

  ata_dma_command_issue_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .command_i      (command),
    .channel_i      (channel),
    .slave_i        (slave),
    .lba_i          (lba),
    .xfer_len_i     (xfer_len),
    .is_write_i     (is_write),
    .tag_i          (tag),
    .bm_error_i     (bm_error),
    .drive_error_i  (drive_error),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .kind_o         (kind_o),
    .port_channel_o (port_channel_o),
    .reg_offset_o   (reg_offset_o),
    .write_value_o  (write_value_o),
    .done_ok_o      (done_ok_o),
    .done_tag_o     (done_tag_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop if the run hangs
  initial begin
    #RUN_LIMIT_NS;
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short pauses, now and then a long one
  function automatic int pause_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  function automatic adq_request_t build_request(logic cmd, logic ch, logic sl,
                                                 logic [47:0] addr, logic [15:0] cnt,
                                                 logic wr, logic [7:0] id,
                                                 logic bm_err, logic drv_err);
    adq_request_t r;
    r.command     = cmd;
    r.channel     = ch;
    r.slave       = sl;
    r.lba         = addr;
    r.count       = cnt;
    r.is_write    = wr;
    r.tag         = id;
    r.bm_error    = bm_err;
    r.drive_error = drv_err;
    return r;
  endfunction

  function automatic adq_request_t random_request(int irq_pct);
    adq_request_t r;
    r.command  = ($urandom_range(0, 99) < irq_pct) ? CMD_IRQ : CMD_SUBMIT;
    r.channel  = 1'($urandom_range(0, 1));
    r.slave    = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       r.lba = '0;
      1:       r.lba = '1;
      default: r.lba = {16'($urandom_range(0, 65535)), 32'($urandom)};
    endcase
    case ($urandom_range(0, 9))
      0:       r.count = '0;
      1:       r.count = '1;
      default: r.count = 16'($urandom_range(0, 65535));
    endcase
    r.is_write    = 1'($urandom_range(0, 1));
    r.tag         = 8'($urandom_range(0, 255));
    r.bm_error    = ($urandom_range(0, 3) == 0);
    r.drive_error = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  // Offer one request and hold it until taken
  task automatic offer_request(adq_request_t r);
    @(negedge clk_i);
    command      <= r.command;
    channel      <= r.channel;
    slave        <= r.slave;
    lba          <= r.lba;
    xfer_len     <= r.count;
    is_write     <= r.is_write;
    tag          <= r.tag;
    bm_error     <= r.bm_error;
    drive_error  <= r.drive_error;
    in_valid     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  // Drop valid for a pause of the given length
  task automatic rest_sender(int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Drain every owed result, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Output side: random stall stretches, one long hold-off on request
  initial begin : receiver
    int   len;
    logic held;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_trigger && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        len = HOLD_CYCLES;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin out_stall <= 1'b0; len = $urandom_range(1, 12); end
          5:             begin out_stall <= 1'b0; len = $urandom_range(20, 60); end
          default:       begin out_stall <= 1'b1; len = pause_len(); end
        endcase
      end
      repeat (len - 1) @(negedge clk_i);
    end
  end

  // Check every result taken by the receiver
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_valid_o && !out_stall) begin
      got.kind  = kind_e'(kind_o);
      got.ch    = port_channel_o;
      got.off   = reg_offset_o;
      got.value = write_value_o;
      got.ok    = done_ok_o;
      got.tag   = done_tag_o;
      got.last  = last_o;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    logic [7:0] dev;
    logic [1:0] mode;
    int         sel;
    int         irq_pct;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: no DMA anywhere, empty queue interrupt
    offer_request(build_request(CMD_SUBMIT, 1'b0, 1'b0, 48'h1, 16'h1, 1'b0, 8'h5A,
                                1'b0, 1'b0));
    offer_request(build_request(CMD_IRQ, 1'b1, 1'b0, '0, '0, 1'b0, 8'h00, 1'b1, 1'b1));
    settle();

    // Reserved addressing on every drive
    write_register(CFG_DEV_ADDR, 32'h0000_00FF);
    write_register(CFG_DMA_CHAN, 32'h0000_0003);
    write_register(CFG_PRDT_PRI, 32'hFFFF_FFFF);
    write_register(CFG_PRDT_SEC, 32'h0000_0000);
    offer_request(build_request(CMD_SUBMIT, 1'b0, 1'b1, 48'h2, 16'h2, 1'b1, 8'h33,
                                1'b0, 1'b0));
    settle();

    // Primary: master LBA28, slave LBA48; secondary: master CHS, slave reserved
    write_register(CFG_DEV_ADDR, {24'h0, MODE_RESERVED, MODE_CHS, MODE_LBA48, MODE_LBA28});
    offer_request(build_request(CMD_SUBMIT, 1'b0, 1'b0, '1, '1, 1'b1, 8'hFF, 1'b0, 1'b0));
    offer_request(build_request(CMD_SUBMIT, 1'b0, 1'b1, '0, '0, 1'b0, 8'h00, 1'b0, 1'b0));
    offer_request(build_request(CMD_SUBMIT, 1'b1, 1'b0, 48'h5, 16'h8, 1'b0, 8'h41,
                                1'b0, 1'b0));
    offer_request(build_request(CMD_SUBMIT, 1'b1, 1'b1, 48'h6, 16'h8, 1'b0, 8'h42,
                                1'b0, 1'b0));
    offer_request(build_request(CMD_IRQ, 1'b0, 1'b0, '0, '0, 1'b0, 8'h00, 1'b1, 1'b0));
    offer_request(build_request(CMD_IRQ, 1'b0, 1'b0, '0, '0, 1'b0, 8'h00, 1'b0, 1'b1));
    offer_request(build_request(CMD_IRQ, 1'b0, 1'b0, '0, '0, 1'b0, 8'h00, 1'b0, 1'b0));
    settle();

    // Fill the secondary queue to the brim, one more gets turned away
    write_register(CFG_DEV_ADDR, {24'h0, MODE_LBA28, MODE_LBA48, MODE_LBA48, MODE_LBA28});
    offer_request(build_request(CMD_SUBMIT, 1'b1, 1'b0, 48'hA5A5_5A5A_C3C3, 16'h1234,
                                1'b1, 8'h11, 1'b0, 1'b0));
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      offer_request(build_request(CMD_SUBMIT, 1'b1, 1'(i), {16'(i), 32'($urandom)},
                                  16'(i * 257), 1'(i >> 1), 8'(8'h20 + i), 1'b0, 1'b0));
    end
    settle();

    // Change settings under queued requests: next issue follows the new ones
    write_register(CFG_DEV_ADDR, 32'h0000_0000);
    write_register(CFG_DMA_CHAN, 32'h0000_0000);
    write_register(CFG_PRDT_SEC, 32'hDEAD_BEEF);
    offer_request(build_request(CMD_IRQ, 1'b1, 1'b0, '0, '0, 1'b0, 8'h00, 1'b0, 1'b0));
    offer_request(build_request(CMD_IRQ, 1'b1, 1'b0, '0, '0, 1'b0, 8'h00, 1'b1, 1'b1));
    offer_request(build_request(CMD_SUBMIT, 1'b1, 1'b0, 48'h7, 16'h1, 1'b0, 8'h77,
                                1'b0, 1'b0));
    settle();

    // Random phases, each under fresh settings
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int d = 0; d < 4; d++) begin
        sel = $urandom_range(0, 11);
        if (sel == 0)      mode = MODE_CHS;
        else if (sel == 1) mode = MODE_RESERVED;
        else if (sel < 7)  mode = MODE_LBA28;
        else               mode = MODE_LBA48;
        dev[d * 2 +: 2] = mode;
      end
      write_register(CFG_DEV_ADDR, {24'h0, dev});
      write_register(CFG_DMA_CHAN, (ph == 2) ? 32'd1 : (ph == 4) ? 32'd2 : 32'd3);
      write_register(CFG_PRDT_PRI, (ph == 1) ? 32'h0000_0000 : 32'($urandom));
      write_register(CFG_PRDT_SEC, (ph == 1) ? 32'hFFFF_FFFF : 32'($urandom));
      irq_pct = (ph == 3) ? 15 : 42;
      // Hold the output back while the sender keeps pushing
      if (ph == 2) hold_trigger = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        offer_request(random_request(irq_pct));
        if (!(ph == 2 && i < 20) && $urandom_range(0, 1) == 0) rest_sender(pause_len());
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
